// ----- hw/rtl/utf8_decoder_with_replacement_assert.svh -----
// Assertion macros for the UTF-8 decoder.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_ASSERT_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS
`define UTF8DEC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("utf8dec assertion failed");
`define UTF8DEC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("utf8dec assertion failed");
`else
`define UTF8DEC_ASSERT(lbl, clk, rst, prop)
`define UTF8DEC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/utf8dec_pkg.sv -----
package utf8dec_pkg;

   localparam int CP_WIDTH = 21;

   localparam logic [CP_WIDTH-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_WIDTH-1:0] CP_MAX_SCALAR  = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] CP_SURR_LOW    = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] CP_SURR_HIGH   = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] CP_MIN_LEN1    = 21'h000080;
   localparam logic [CP_WIDTH-1:0] CP_MIN_LEN2    = 21'h000800;
   localparam logic [CP_WIDTH-1:0] CP_MIN_LEN3    = 21'h010000;
   localparam logic [CP_WIDTH-1:0] CP_FIRST_SHOWN = 21'h000020;
   localparam logic [CP_WIDTH-1:0] CP_DELETE      = 21'h00007F;

   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                run_last;
   } entry_type;

   // results written into the output queue in the same cycle
   typedef struct packed {
      logic [1:0] count;
      entry_type  e0;
      entry_type  e1;
   } push_type;

endpackage

// ----- hw/rtl/utf8dec_core.sv -----
`include "utf8_decoder_with_replacement_assert.svh"

module utf8dec_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_fire,
   input  logic [7:0]          in_byte,
   input  logic                in_end,
   output utf8dec_pkg::push_type push
);
   import utf8dec_pkg::*;

   logic [CP_WIDTH-1:0] accum_ff, accum_in;
   logic [1:0]          rem_ff, rem_in;
   logic [1:0]          len_ff, len_in;

   logic [1:0]          lead_len;
   logic [CP_WIDTH-1:0] lead_val;
   logic                lead_push;
   logic [CP_WIDTH-1:0] lead_cp;
   logic                cont;
   logic [CP_WIDTH-1:0] acc_shift;
   logic [1:0]          rem_dec;
   logic                pa_v, pb_v, a_keep, b_keep;
   logic [CP_WIDTH-1:0] pa, pb;

   function automatic logic [CP_WIDTH-1:0] check_done(input logic [CP_WIDTH-1:0] v,
                                                     input logic [1:0] len);
      logic bad;
      begin
         bad = (len == 2'd1 && v < CP_MIN_LEN1) || (len == 2'd2 && v < CP_MIN_LEN2) ||
               (len == 2'd3 && v < CP_MIN_LEN3) ||
               (v >= CP_SURR_LOW && v <= CP_SURR_HIGH) || (v > CP_MAX_SCALAR);
         check_done = bad ? CP_REPLACEMENT : v;
      end
   endfunction

   function automatic logic dropped(input logic [CP_WIDTH-1:0] v);
      dropped = (v < CP_FIRST_SHOWN) || (v == CP_DELETE);
   endfunction

   always_comb begin
      if (in_byte inside {[8'hC2:8'hDF]}) begin
         lead_len = 2'd1;
         lead_val = {16'd0, in_byte[4:0]};
      end else if (in_byte inside {[8'hE0:8'hEF]}) begin
         lead_len = 2'd2;
         lead_val = {17'd0, in_byte[3:0]};
      end else if (in_byte inside {[8'hF0:8'hF4]}) begin
         lead_len = 2'd3;
         lead_val = {18'd0, in_byte[2:0]};
      end else begin
         lead_len = 2'd0;
         lead_val = in_byte[7] ? CP_REPLACEMENT : {13'd0, in_byte};
      end
      lead_push = (lead_len == 2'd0) || in_end;
      lead_cp   = (lead_len == 2'd0) ? lead_val : CP_REPLACEMENT;
   end

   assign cont      = (in_byte[7:6] == 2'b10);
   assign acc_shift = {accum_ff[CP_WIDTH-7:0], in_byte[5:0]};
   assign rem_dec   = rem_ff - 2'd1;

   always_comb begin
      pa_v     = 1'b0;
      pa       = '0;
      pb_v     = 1'b0;
      pb       = '0;
      accum_in = accum_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      if (rem_ff != 2'd0 && cont) begin
         if (rem_dec == 2'd0) begin
            pa_v     = 1'b1;
            pa       = check_done(acc_shift, len_ff);
            accum_in = '0;
            rem_in   = 2'd0;
            len_in   = 2'd0;
         end else if (in_end) begin
            pa_v     = 1'b1;
            pa       = CP_REPLACEMENT;
            accum_in = '0;
            rem_in   = 2'd0;
            len_in   = 2'd0;
         end else begin
            accum_in = acc_shift;
            rem_in   = rem_dec;
         end
      end else begin
         // no open sequence, or a broken one: replace an open one, then treat the byte as a lead
         if (rem_ff != 2'd0) begin
            pa_v = 1'b1;
            pa   = CP_REPLACEMENT;
            pb_v = lead_push;
            pb   = lead_cp;
         end else begin
            pa_v = lead_push;
            pa   = lead_cp;
         end
         if (lead_len != 2'd0 && !in_end) begin
            accum_in = lead_val;
            rem_in   = lead_len;
            len_in   = lead_len;
         end else begin
            accum_in = '0;
            rem_in   = 2'd0;
            len_in   = 2'd0;
         end
      end
   end

   assign a_keep = in_fire && pa_v && !dropped(pa);
   assign b_keep = in_fire && pb_v && !dropped(pb);

   always_comb begin
      push.count         = {1'b0, a_keep} + {1'b0, b_keep};
      push.e0.code_point = a_keep ? pa : pb;
      push.e0.run_last   = !(a_keep && b_keep);
      push.e1.code_point = pb;
      push.e1.run_last   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         rem_ff   <= 2'd0;
         len_ff   <= 2'd0;
      end else if (in_fire) begin
         accum_ff <= accum_in;
         rem_ff   <= rem_in;
         len_ff   <= len_in;
      end
   end

   `UTF8DEC_ASSERT(a_rem_within_len, clock, reset, len_ff >= rem_ff)
   `UTF8DEC_ASSERT(a_idle_clean, clock, reset, (rem_ff == 2'd0) |-> (accum_ff == '0 && len_ff == 2'd0))
   `UTF8DEC_ASSERT(a_two_needs_open, clock, reset, (push.count == PUSH_TWO) |-> (rem_ff != 2'd0))

endmodule

// ----- hw/rtl/utf8dec_outq.sv -----
`include "utf8_decoder_with_replacement_assert.svh"

module utf8dec_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  utf8dec_pkg::push_type push,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_stall,
   output utf8dec_pkg::entry_type out_entry
);
   import utf8dec_pkg::*;

   entry_type  mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign space     = (count_ff <= 3'd2);

   assign wr_next   = wr_ptr_ff + 2'd1;
   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push.count} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (push.count != PUSH_NONE) begin
         mem_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.count == PUSH_TWO) begin
         mem_ff[wr_next] <= push.e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UTF8DEC_ASSERT(a_count_bound, clock, reset, count_ff <= 3'd4)
   `UTF8DEC_ASSERT(a_push_fits, clock, reset, (push.count != PUSH_NONE) |-> space)
   `UTF8DEC_ASSERT(a_last_pop_empties, clock, reset, (pop && push.count == PUSH_NONE && count_ff == 3'd1 && !reset) |=> !out_valid)

endmodule

// ----- hw/rtl/utf8_decoder_with_replacement.sv -----
// Channel  Direction  Handshake            Fields
// req      in         req_valid/req_stall  req_data_byte, req_string_end
// rsp      out        rsp_valid/rsp_stall  rsp_code_point, rsp_run_last
//
// One byte accepted per cycle while req_stall is low. A byte waits in the input
// register, then its results go into the result queue; a byte giving two code
// points gives two results in turn. req_stall rises while the input register
// is full and the four-entry result queue has fewer than two free slots.
// Synchronous reset empties the pipeline and queue and idles the decoder.

module utf8_decoder_with_replacement (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_run_last
);
   import utf8dec_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       space;
   logic       advance;
   logic       req_fire;
   push_type   push;
   entry_type  head;

   assign advance   = in_valid_ff && space;
   assign req_stall = in_valid_ff && !space;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_string_end;
      end
   end

   utf8dec_core u_core (
      .clock   (clock),
      .reset   (reset),
      .in_fire (advance),
      .in_byte (in_byte_ff),
      .in_end  (in_end_ff),
      .push    (push)
   );

   utf8dec_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_entry (head)
   );

   assign rsp_code_point = head.code_point;
   assign rsp_run_last   = head.run_last;

endmodule

// ----- tb/sv/utf8_decode_checker.sv -----
`timescale 1ns / 1ps

module utf8_decode_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_string_end,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [utf8dec_pkg::CP_WIDTH-1:0] rsp_code_point,
   input  logic                             rsp_run_last,
   output int                               error_count,
   output int                               outstanding
);
   import utf8dec_pkg::*;

   entry_type           expected_points[$];
   logic [CP_WIDTH-1:0] step_points[$];
   logic [CP_WIDTH-1:0] cp_accum;
   logic [1:0]          cont_left;
   logic [1:0]          cont_total;
   int                  fail_tally = 0;

   function automatic logic [CP_WIDTH-1:0] finish_scalar(input logic [CP_WIDTH-1:0] v,
                                                         input logic [1:0] len);
      if ((len == 2'd1 && v < CP_MIN_LEN1) || (len == 2'd2 && v < CP_MIN_LEN2) ||
          (len == 2'd3 && v < CP_MIN_LEN3) ||
          (v >= CP_SURR_LOW && v <= CP_SURR_HIGH) || v > CP_MAX_SCALAR)
         return CP_REPLACEMENT;
      return v;
   endfunction

   task automatic enter_idle();
      cp_accum   = '0;
      cont_left  = '0;
      cont_total = '0;
   endtask

   // control codes and DEL give nothing
   task automatic emit_point(input logic [CP_WIDTH-1:0] v);
      if (v >= CP_FIRST_SHOWN && v != CP_DELETE)
         step_points = {step_points, v};
   endtask

   task automatic open_sequence(input logic [7:0] octet, input logic is_end);
      logic [1:0]          len;
      logic [CP_WIDTH-1:0] v;
      len = 2'd0;
      v   = {13'd0, octet};
      if (octet >= 8'hC2 && octet <= 8'hDF) begin
         v   = {16'd0, octet[4:0]};
         len = 2'd1;
      end else if (octet >= 8'hE0 && octet <= 8'hEF) begin
         v   = {17'd0, octet[3:0]};
         len = 2'd2;
      end else if (octet >= 8'hF0 && octet <= 8'hF4) begin
         v   = {18'd0, octet[2:0]};
         len = 2'd3;
      end else if (octet[7]) begin
         v = CP_REPLACEMENT;
      end
      if (len == 2'd0) begin
         emit_point(v);
      end else if (is_end) begin
         emit_point(CP_REPLACEMENT);
         enter_idle();
      end else begin
         cp_accum   = v;
         cont_left  = len;
         cont_total = len;
      end
   endtask

   task automatic predict_octet(input logic [7:0] octet, input logic is_end);
      entry_type e;
      if (cont_left != 2'd0) begin
         if (octet[7:6] == 2'b10) begin
            cp_accum  = {cp_accum[CP_WIDTH-7:0], octet[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               emit_point(finish_scalar(cp_accum, cont_total));
               enter_idle();
            end else if (is_end) begin
               emit_point(CP_REPLACEMENT);
               enter_idle();
            end
         end else begin
            // broken sequence: replace it, then take the item as a fresh lead
            emit_point(CP_REPLACEMENT);
            enter_idle();
            open_sequence(octet, is_end);
         end
      end else begin
         open_sequence(octet, is_end);
      end
      foreach (step_points[i]) begin
         e.code_point = step_points[i];
         e.run_last   = (i == step_points.size() - 1);
         expected_points = {expected_points, e};
      end
      step_points.delete();
   endtask

   always @(posedge clock) begin
      entry_type want;
      if (reset) begin
         expected_points.delete();
         enter_idle();
      end else begin
         if (req_valid && !req_stall)
            predict_octet(req_data_byte, req_string_end);
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               fail_tally++;
               $error("unexpected result: code_point %h run_last %b",
                      rsp_code_point, rsp_run_last);
            end else begin
               want = expected_points.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  fail_tally++;
                  $error("code_point: expected %h, got %h", want.code_point, rsp_code_point);
               end
               if (rsp_run_last !== want.run_last) begin
                  fail_tally++;
                  $error("run_last: expected %b, got %b", want.run_last, rsp_run_last);
               end
            end
         end
      end
      error_count <= fail_tally;
      outstanding <= expected_points.size();
   end

endmodule

// ----- tb/sv/tb_utf8_decoder_with_replacement.sv -----
`timescale 1ns / 1ps

module tb_utf8_decoder_with_replacement;
   import utf8dec_pkg::*;

   localparam int ITEM_TOTAL  = 1150;
   localparam int HOLD_AT     = 300;
   localparam int QUIET_FROM  = 950;
   localparam int LONG_HOLD   = 80;
   localparam int CYCLE_LIMIT = 200000;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic [7:0]          req_data_byte  = 8'd0;
   logic                req_string_end = 1'b0;
   logic                rsp_stall      = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [CP_WIDTH-1:0] rsp_code_point;
   logic                rsp_run_last;

   int error_count;
   int outstanding;
   int bytes_sent  = 0;
   int cycle_count = 0;
   bit gaps_on      = 1'b1;
   bit quiet        = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;

   // {string_end, byte}
   logic [8:0] directed_octets[27] = '{
      9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0C0, 9'h080, 9'h0FF,
      9'h0E0, 9'h080, 9'h080, 9'h0ED, 9'h0A0, 9'h080,
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0F4, 9'h090, 9'h080, 9'h080,
      9'h0E2, 9'h041, 9'h0E2, 9'h1C3, 9'h0E2, 9'h182
   };

   utf8_decoder_with_replacement dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_run_last   (rsp_run_last)
   );

   utf8_decode_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_run_last   (rsp_run_last),
      .error_count    (error_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** utf8_decoder_with_replacement: FAILED **");
         $finish;
      end
   end

   function automatic logic pick_end();
      return $urandom_range(0, 15) == 0;
   endfunction

   task automatic send_octet(input logic [7:0] octet, input logic is_end);
      if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= octet;
      req_string_end <= is_end;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (bytes_sent % 64 == 0)
         gaps_on = $urandom_range(0, 3) != 0;
   endtask

   // mostly well-formed sequences, some broken, some noise
   task automatic send_sequence();
      int         kind;
      int         len;
      logic [7:0] lead;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         send_octet(8'($urandom_range(0, 127)), pick_end());
      end else if (kind < 85) begin
         if (kind < 50) begin
            lead = 8'($urandom_range(8'hC2, 8'hDF));
            len  = 1;
         end else if (kind < 70) begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            len  = 2;
         end else begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            len  = 3;
         end
         send_octet(lead, pick_end());
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
               send_octet(8'($urandom_range(0, 255)), pick_end());
            else
               send_octet(8'($urandom_range(8'h80, 8'hBF)), pick_end());
         end
      end else begin
         send_octet(8'($urandom_range(0, 255)), pick_end());
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && !quiet && gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_octets[i])
         send_octet(directed_octets[i][7:0], directed_octets[i][8]);
      while (bytes_sent < ITEM_TOTAL) begin
         if (bytes_sent >= HOLD_AT && !hold_done) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         quiet = bytes_sent >= QUIET_FROM;
         send_sequence();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("** utf8_decoder_with_replacement: PASSED **");
      else
         $display("** utf8_decoder_with_replacement: FAILED **");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/utf8dec_pkg.sv
hw/rtl/utf8dec_core.sv
hw/rtl/utf8dec_outq.sv
hw/rtl/utf8_decoder_with_replacement.sv
tb/sv/utf8_decode_checker.sv
tb/sv/tb_utf8_decoder_with_replacement.sv
